FILE: sv/round_robin_scheduler_partitions_top_defines.svh
// Assertion macros for the scheduler RTL (used by the datapath).
// Needs clk and arst_n in the scope that uses them.
`ifndef ROUND_ROBIN_SCHEDULER_PARTITIONS_TOP_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULER_PARTITIONS_TOP_DEFINES_SVH

// same-cycle implication
`define RRSP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrsp check failed");

// next-cycle implication
`define RRSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrsp check failed");

`endif

FILE: sv/rrsp_pkg.sv
// Shared types and constants for the round-robin scheduler.
// No dependencies.
`timescale 1ns / 1ps

package rrsp_pkg;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_READY   = 3'd1;
	localparam logic [2:0] ST_RUNNING = 3'd2;
	localparam logic [2:0] ST_WAITING = 3'd3;
	localparam logic [2:0] ST_TERM    = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_REC  = 1'b0;
	localparam logic KIND_STAT = 1'b1;

	localparam logic [2:0] CFG_QUANTUM = 3'd0;
	localparam logic [2:0] CFG_PART0   = 3'd1;

	localparam logic [16:0] IO_NEVER = 17'd99999;
	localparam logic [15:0] QUANTUM_RST = 16'd100;
	localparam logic [7:0] PART_RST [6] = '{8'd40, 8'd25, 8'd15, 8'd10, 8'd8, 8'd2};

	typedef struct packed {
		logic [2:0]  state;
		logic [2:0]  logged;
		logic [15:0] pid;
		logic [7:0]  mem;
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [16:0] io_every;
		logic [15:0] io_wait;
		logic [15:0] cooldown;
		logic [16:0] budget;
		logic [15:0] quantum;
	} slot_rec_t;

	typedef enum logic [2:0] {
		PH_SCAN  = 3'd0,
		PH_RUN   = 3'd1,
		PH_PICK  = 3'd2,
		PH_COUNT = 3'd3,
		PH_STAT  = 3'd4
	} phase_t;

	typedef struct packed {
		logic   start;
		logic   load;
		logic   rd;
		logic   ex;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic need_emit;
		logic blocked;
		logic idx_last;
		logic no_slots;
	} stat_t;

	function automatic logic [15:0] dec16(input logic [15:0] v);
		return (v != 16'd0) ? v - 16'd1 : 16'd0;
	endfunction

	function automatic logic [16:0] dec17(input logic [16:0] v);
		return (v != 17'd0) ? v - 17'd1 : 17'd0;
	endfunction

endpackage

FILE: sv/rrsp_ctrl.sv
// Sequencer for the scheduler: walks the per-tick passes.
// Depends on rrsp_pkg.
`timescale 1ns / 1ps

module rrsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          opcode,
	output logic          in_stall,
	input  rrsp_pkg::stat_t st,
	output rrsp_pkg::cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_ARD  = 10'b0000000010,
		S_AEX  = 10'b0000000100,
		S_RRD  = 10'b0000001000,
		S_REX  = 10'b0000010000,
		S_PRD  = 10'b0000100000,
		S_PEX  = 10'b0001000000,
		S_CRD  = 10'b0010000000,
		S_CEX  = 10'b0100000000,
		S_STAT = 10'b1000000000
	} fsm_t;

	fsm_t state_q, state_d;
	logic go;

	assign go = !(st.need_emit && st.blocked);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.load  = 1'b0;
		cmd.rd    = 1'b0;
		cmd.ex    = 1'b0;
		cmd.phase = rrsp_pkg::PH_STAT;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == rrsp_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d = st.no_slots ? S_RRD : S_ARD;
					end
				end
			end
			S_ARD: begin
				cmd.phase = rrsp_pkg::PH_SCAN;
				cmd.rd = 1'b1;
				state_d = S_AEX;
			end
			S_AEX: begin
				cmd.phase = rrsp_pkg::PH_SCAN;
				if (go) begin
					cmd.ex = 1'b1;
					state_d = st.idx_last ? S_RRD : S_ARD;
				end
			end
			S_RRD: begin
				cmd.phase = rrsp_pkg::PH_RUN;
				cmd.rd = 1'b1;
				state_d = S_REX;
			end
			S_REX: begin
				cmd.phase = rrsp_pkg::PH_RUN;
				if (go) begin
					cmd.ex = 1'b1;
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				cmd.phase = rrsp_pkg::PH_PICK;
				cmd.rd = 1'b1;
				state_d = S_PEX;
			end
			S_PEX: begin
				cmd.phase = rrsp_pkg::PH_PICK;
				if (go) begin
					cmd.ex = 1'b1;
					state_d = st.no_slots ? S_STAT : S_CRD;
				end
			end
			S_CRD: begin
				cmd.phase = rrsp_pkg::PH_COUNT;
				cmd.rd = 1'b1;
				state_d = S_CEX;
			end
			S_CEX: begin
				cmd.phase = rrsp_pkg::PH_COUNT;
				cmd.ex = 1'b1;
				state_d = st.idx_last ? S_STAT : S_CRD;
			end
			S_STAT: begin
				cmd.phase = rrsp_pkg::PH_STAT;
				if (go) begin
					cmd.ex = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/rrsp_dp.sv
// Scheduler datapath: slot memory, partitions, counters, result register.
// Depends on rrsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "round_robin_scheduler_partitions_top_defines.svh"

module rrsp_dp #(
	parameter int MAX_PROCS = 16,
	parameter int NUM_PARTS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rrsp_pkg::cmd_t  cmd,
	output rrsp_pkg::stat_t st,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [15:0]   wr_data,
	input  logic [15:0]   proc_id,
	input  logic [7:0]    mem_need,
	input  logic [15:0]   arrival_ticks,
	input  logic [15:0]   cpu_ticks,
	input  logic [15:0]   io_every,
	input  logic [15:0]   io_wait,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          kind,
	output logic [31:0]   stamp,
	output logic [15:0]   who,
	output logic [2:0]    from_state,
	output logic [2:0]    to_state,
	output logic          all_done,
	output logic          last
);

	localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);

	rrsp_pkg::slot_rec_t mem_q [MAX_PROCS];
	rrsp_pkg::slot_rec_t rd_q, nrec, load_rec;

	logic [15:0]   quantum_cfg_q;
	logic [7:0]    part_size_q [NUM_PARTS];
	logic [NUM_PARTS-1:0] busy_q;
	logic [15:0]   owner_q [NUM_PARTS];

	logic [CW-1:0] loaded_q;
	logic [IW-1:0] idx_q, run_slot_q, first_idx_q, pick_q, addr, pick_d;
	logic          run_v_q, first_v_q, pick_v_q, done_q, pick_v_d;
	logic [31:0]   tick_q;

	logic [NUM_PARTS-1:0] fit_oh;
	logic          admit, wake, term, wt, pre, emit, run_after, wr_slot;
	logic [2:0]    eto, st_mid;

	logic          out_valid_q, kind_q, all_done_q, last_q;
	logic [31:0]   stamp_q;
	logic [15:0]   who_q;
	logic [2:0]    from_q, to_q;

	always_comb begin
		case (cmd.phase)
			rrsp_pkg::PH_RUN:  addr = run_slot_q;
			rrsp_pkg::PH_PICK: addr = pick_q;
			default:           addr = idx_q;
		endcase
	end

	// highest free partition that fits wins
	always_comb begin
		fit_oh = '0;
		for (int p = 0; p < NUM_PARTS; p++) begin
			if (!busy_q[p] && part_size_q[p] >= rd_q.mem) begin
				fit_oh = '0;
				fit_oh[p] = 1'b1;
			end
		end
	end

	always_comb begin
		nrec      = rd_q;
		emit      = 1'b0;
		eto       = rrsp_pkg::ST_NEW;
		admit     = 1'b0;
		wake      = 1'b0;
		term      = 1'b0;
		wt        = 1'b0;
		pre       = 1'b0;
		st_mid    = rd_q.state;
		run_after = run_v_q;
		pick_d    = first_idx_q;
		pick_v_d  = 1'b0;
		case (cmd.phase)
			rrsp_pkg::PH_SCAN: begin
				admit = (rd_q.state == rrsp_pkg::ST_NEW) && (rd_q.arrival == 16'd0)
					&& (|fit_oh);
				st_mid = admit ? rrsp_pkg::ST_WAITING : rd_q.state;
				wake = (st_mid == rrsp_pkg::ST_WAITING) && (rd_q.cooldown == 16'd0);
				nrec.state = st_mid;
				if (wake) begin
					emit = 1'b1;
					eto = rrsp_pkg::ST_READY;
					nrec.budget = rd_q.io_every;
					nrec.cooldown = rd_q.io_wait;
				end
			end
			rrsp_pkg::PH_RUN: begin
				if (run_v_q) begin
					term = (rd_q.remaining == 16'd0);
					wt = !term && (rd_q.budget == 17'd0);
					pre = !term && !wt && (rd_q.quantum == 16'd0);
				end
				run_after = run_v_q && !(term || wt || pre);
				if (term) begin
					emit = 1'b1;
					eto = rrsp_pkg::ST_TERM;
				end else if (wt) begin
					emit = 1'b1;
					eto = rrsp_pkg::ST_WAITING;
				end else if (pre) begin
					emit = 1'b1;
					eto = rrsp_pkg::ST_READY;
					nrec.quantum = quantum_cfg_q;
				end
				// preempted slot competes with the scan's first ready slot
				if (pre && !(first_v_q && first_idx_q < run_slot_q)) begin
					pick_d = run_slot_q;
				end
				pick_v_d = !run_after && (pre || first_v_q);
			end
			rrsp_pkg::PH_PICK: begin
				if (pick_v_q) begin
					emit = 1'b1;
					eto = rrsp_pkg::ST_RUNNING;
				end
			end
			rrsp_pkg::PH_COUNT: begin
				if (rd_q.state == rrsp_pkg::ST_RUNNING) begin
					nrec.budget = rrsp_pkg::dec17(rd_q.budget);
					nrec.remaining = rrsp_pkg::dec16(rd_q.remaining);
					nrec.quantum = rrsp_pkg::dec16(rd_q.quantum);
				end else if (rd_q.state == rrsp_pkg::ST_WAITING) begin
					nrec.cooldown = rrsp_pkg::dec16(rd_q.cooldown);
				end else if (rd_q.state == rrsp_pkg::ST_NEW) begin
					nrec.arrival = rrsp_pkg::dec16(rd_q.arrival);
				end
			end
			rrsp_pkg::PH_STAT: emit = 1'b1;
			default: ;
		endcase
		if (emit && cmd.phase != rrsp_pkg::PH_STAT) begin
			nrec.state = eto;
			nrec.logged = eto;
		end
	end

	assign wr_slot = cmd.ex && (cmd.phase != rrsp_pkg::PH_STAT);

	always_comb begin
		load_rec.state     = rrsp_pkg::ST_NEW;
		load_rec.logged    = rrsp_pkg::ST_NEW;
		load_rec.pid       = proc_id;
		load_rec.mem       = mem_need;
		load_rec.arrival   = arrival_ticks;
		load_rec.remaining = cpu_ticks;
		load_rec.io_every  = (io_every == 16'd0) ? rrsp_pkg::IO_NEVER : {1'b0, io_every};
		load_rec.io_wait   = io_wait;
		load_rec.cooldown  = 16'd0;
		load_rec.budget    = 17'd0;
		load_rec.quantum   = quantum_cfg_q;
	end

	// slot memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.load && loaded_q < CW'(MAX_PROCS)) begin
			mem_q[loaded_q[IW-1:0]] <= load_rec;
		end else if (wr_slot) begin
			mem_q[addr] <= nrec;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_cfg_q <= rrsp_pkg::QUANTUM_RST;
			for (int p = 0; p < NUM_PARTS; p++) begin
				part_size_q[p] <= rrsp_pkg::PART_RST[p];
				owner_q[p] <= 16'd0;
			end
			busy_q      <= '0;
			loaded_q    <= '0;
			idx_q       <= '0;
			run_slot_q  <= '0;
			run_v_q     <= 1'b0;
			first_idx_q <= '0;
			first_v_q   <= 1'b0;
			pick_q      <= '0;
			pick_v_q    <= 1'b0;
			done_q      <= 1'b1;
			tick_q      <= 32'd0;
		end else begin
			if (wr_en) begin
				if (wr_index == rrsp_pkg::CFG_QUANTUM) begin
					quantum_cfg_q <= wr_data;
				end
				for (int p = 0; p < NUM_PARTS; p++) begin
					if (wr_index == rrsp_pkg::CFG_PART0 + 3'(p)) begin
						part_size_q[p] <= wr_data[7:0];
					end
				end
			end
			if (cmd.load && loaded_q < CW'(MAX_PROCS)) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (cmd.start) begin
				idx_q <= '0;
				first_v_q <= 1'b0;
				done_q <= 1'b1;
			end
			if (cmd.ex) begin
				case (cmd.phase)
					rrsp_pkg::PH_SCAN: begin
						idx_q <= idx_q + IW'(1);
						if (admit) begin
							for (int p = 0; p < NUM_PARTS; p++) begin
								if (fit_oh[p]) begin
									busy_q[p] <= 1'b1;
									owner_q[p] <= rd_q.pid;
								end
							end
						end
						if (nrec.state == rrsp_pkg::ST_READY && !first_v_q) begin
							first_v_q <= 1'b1;
							first_idx_q <= idx_q;
						end
					end
					rrsp_pkg::PH_RUN: begin
						if (term) begin
							for (int p = 0; p < NUM_PARTS; p++) begin
								if (busy_q[p] && owner_q[p] == rd_q.pid) begin
									busy_q[p] <= 1'b0;
									owner_q[p] <= 16'd0;
								end
							end
						end
						run_v_q <= run_after;
						pick_q <= pick_d;
						pick_v_q <= pick_v_d;
					end
					rrsp_pkg::PH_PICK: begin
						idx_q <= '0;
						if (pick_v_q) begin
							run_v_q <= 1'b1;
							run_slot_q <= pick_q;
						end
					end
					rrsp_pkg::PH_COUNT: begin
						idx_q <= idx_q + IW'(1);
						if (rd_q.state != rrsp_pkg::ST_TERM) begin
							done_q <= 1'b0;
						end
					end
					rrsp_pkg::PH_STAT: tick_q <= tick_q + 32'd1;
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ex && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ex && emit) begin
			stamp_q <= tick_q;
			if (cmd.phase == rrsp_pkg::PH_STAT) begin
				kind_q <= rrsp_pkg::KIND_STAT;
				who_q <= 16'd0;
				from_q <= rrsp_pkg::ST_NEW;
				to_q <= rrsp_pkg::ST_NEW;
				all_done_q <= done_q;
				last_q <= 1'b1;
			end else begin
				kind_q <= rrsp_pkg::KIND_REC;
				who_q <= rd_q.pid;
				from_q <= rd_q.logged;
				to_q <= eto;
				all_done_q <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign stamp      = stamp_q;
	assign who        = who_q;
	assign from_state = from_q;
	assign to_state   = to_q;
	assign all_done   = all_done_q;
	assign last       = last_q;

	assign st.need_emit = emit;
	assign st.blocked   = out_valid_q && out_stall;
	assign st.idx_last  = (CW'(idx_q) == loaded_q - CW'(1));
	assign st.no_slots  = (loaded_q == '0);

	`RRSP_ASSERT_IMPL(a_loaded_bound, 1'b1, loaded_q <= CW'(MAX_PROCS))
	`RRSP_ASSERT_IMPL(a_run_in_range, run_v_q, CW'(run_slot_q) < loaded_q)
	`RRSP_ASSERT_IMPL(a_no_overwrite, cmd.ex && emit, !(out_valid_q && out_stall))
	`RRSP_ASSERT_NEXT(a_tick_adv, cmd.ex && cmd.phase == rrsp_pkg::PH_STAT,
		tick_q == $past(tick_q) + 32'd1)

endmodule

FILE: sv/round_robin_scheduler_partitions_top.sv
// Round-robin scheduler with fixed memory partitions, top level.
// Load word: accepted while idle, no result. Tick word with L loaded slots: two
// passes over the single-port slot memory (a read and an execute step per slot),
// then the status word; a step that emits waits while the result side stalls.
// One result register.
// Reset (arst_n low, asynchronous): no slots, tick count zero, all partitions free.
`timescale 1ns / 1ps

module round_robin_scheduler_partitions_top #(
	parameter int MAX_PROCS = 16,
	parameter int NUM_PARTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] proc_id,
	input  logic [7:0]  mem_need,
	input  logic [15:0] arrival_ticks,
	input  logic [15:0] cpu_ticks,
	input  logic [15:0] io_every,
	input  logic [15:0] io_wait,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [31:0] stamp,
	output logic [15:0] who,
	output logic [2:0]  from_state,
	output logic [2:0]  to_state,
	output logic        all_done,
	output logic        last
);

	// Per tick the sequencer runs: admit/wake scan over all slots, handling of
	// the running slot, dispatch of the chosen ready slot, the counter pass,
	// then the status word. Record words go out as each step produces them;
	// a step that emits a word waits while the result register is full and stalled.
	// Quantum and partition sizes return to their defaults on reset.
	rrsp_pkg::cmd_t  cmd;
	rrsp_pkg::stat_t st;

	rrsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	rrsp_dp #(
		.MAX_PROCS (MAX_PROCS),
		.NUM_PARTS (NUM_PARTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.proc_id       (proc_id),
		.mem_need      (mem_need),
		.arrival_ticks (arrival_ticks),
		.cpu_ticks     (cpu_ticks),
		.io_every      (io_every),
		.io_wait       (io_wait),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.stamp         (stamp),
		.who           (who),
		.from_state    (from_state),
		.to_state      (to_state),
		.all_done      (all_done),
		.last          (last)
	);

endmodule
